>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the tokenizer core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// ante in a cycle requires cons in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/dtok_pkg.sv
// ----------------------------------------------------------------------------
// dtok_pkg
// Shared types, token codes, keyword table and character helpers for the
// C declaration tokenizer.
// ----------------------------------------------------------------------------
package dtok_pkg;

    localparam int OFFSET_BITS_DEF     = 32;
    localparam int LINE_BITS_DEF       = 24;
    localparam int KEYWORD_MAX_LEN_DEF = 8;

    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 4;
    localparam int KW_COUNT    = 15;

    // token kinds
    localparam logic [4:0] K_EOF        = 5'd0;
    localparam logic [4:0] K_IDENT      = 5'd1;
    localparam logic [4:0] K_NUMBER     = 5'd2;
    localparam logic [4:0] K_STRING     = 5'd3;
    localparam logic [4:0] K_KW_BASE    = 5'd4;
    localparam logic [4:0] K_SEMI       = 5'd19;
    localparam logic [4:0] K_COMMA      = 5'd20;
    localparam logic [4:0] K_LBRACE     = 5'd21;
    localparam logic [4:0] K_RBRACE     = 5'd22;
    localparam logic [4:0] K_LPAREN     = 5'd23;
    localparam logic [4:0] K_RPAREN     = 5'd24;
    localparam logic [4:0] K_LBRACKET   = 5'd25;
    localparam logic [4:0] K_RBRACKET   = 5'd26;
    localparam logic [4:0] K_COLON      = 5'd27;
    localparam logic [4:0] K_STAR       = 5'd28;
    localparam logic [4:0] K_ASSIGN     = 5'd29;
    localparam logic [4:0] K_OTHER      = 5'd30;

    // characters with a role in the scanner
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // keyword text, right-justified, first character in the highest used byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("struct"), 64'("union"), 64'("enum"), 64'("typedef"), 64'("const"),
        64'("volatile"), 64'("unsigned"), 64'("signed"), 64'("short"),
        64'("long"), 64'("int"), 64'("char"), 64'("void"), 64'("float"),
        64'("double")
    };
    localparam int KW_LEN [KW_COUNT] = '{6, 5, 4, 7, 5, 8, 8, 6, 5, 4, 3, 4, 4, 5, 6};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [23:0] token_line;
        logic [31:0] token_offset;
        logic [31:0] token_length;
        logic        run_last;
    } res_t;

    // results of one scanned byte, in order, slot 0 first
    typedef struct packed {
        logic [1:0]                   n;
        res_t [MAX_RESULTS-1:0]       slot;
    } push_t;

    typedef struct packed {
        logic [2:0] count;
        logic       room;
    } fifo_stat_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h3B:   k = K_SEMI;
            8'h2C:   k = K_COMMA;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h5B:   k = K_LBRACKET;
            8'h5D:   k = K_RBRACKET;
            8'h3A:   k = K_COLON;
            8'h2A:   k = K_STAR;
            8'h3D:   k = K_ASSIGN;
            default: k = K_OTHER;
        endcase
        return k;
    endfunction

endpackage

>>> hdl/dtok_kw_match.sv
// ----------------------------------------------------------------------------
// dtok_kw_match
// Compares the buffered identifier prefix against the type keyword table.
// ----------------------------------------------------------------------------
module dtok_kw_match #(
    parameter int KwMax = dtok_pkg::KEYWORD_MAX_LEN_DEF,
    parameter int LenW  = $clog2(KwMax + 1)
) (
    input  logic [KwMax-1:0][7:0] chars,
    input  logic [LenW-1:0]       len,
    input  logic                  too_long,
    output logic                  hit,
    output logic [4:0]            kind
);

    logic [63:0] word;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            word[8*(7-i) +: 8] = chars[i];
        end
    end

    always_comb
    begin
        hit  = 1'b0;
        kind = dtok_pkg::K_IDENT;
        for (int k = 0; k < dtok_pkg::KW_COUNT; k++)
        begin
            if (!hit && !too_long && (len == LenW'(dtok_pkg::KW_LEN[k]))
                && ((word >> (8 * (8 - dtok_pkg::KW_LEN[k]))) == dtok_pkg::KW_TEXT[k]))
            begin
                hit  = 1'b1;
                kind = 5'(int'(dtok_pkg::K_KW_BASE) + k);
            end
        end
    end

endmodule

>>> hdl/dtok_scan.sv
// ----------------------------------------------------------------------------
// dtok_scan
// Scanner state machine: takes one registered byte, updates the scan state
// and produces up to three ordered token words for that byte.
// ----------------------------------------------------------------------------
module dtok_scan #(
    parameter int OffW  = dtok_pkg::OFFSET_BITS_DEF,
    parameter int LineW = dtok_pkg::LINE_BITS_DEF,
    parameter int KwMax = dtok_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dtok_pkg::in_word_t item,
    output dtok_pkg::push_t   push
);

    localparam int LenW = $clog2(KwMax + 1);
    localparam int IdxW = $clog2(KwMax);

    typedef enum logic [3:0] {
        M_IDLE,
        M_IDENT,
        M_NUMBER,
        M_STRING,
        M_STR_ESC,
        M_SLASH,
        M_LINE_CMT,
        M_BLOCK_CMT,
        M_BLOCK_STAR
    } mode_t;

    mode_t                  mode_reg, mode_s, mode_next;
    logic [OffW-1:0]        off_reg, off_s, off_next;
    logic [LineW-1:0]       line_reg, line_s, line_next;
    logic [OffW-1:0]        start_reg, start_s, start_next;
    logic [LineW-1:0]       sline_reg, sline_s, sline_next;
    logic [KwMax-1:0][7:0]  chars_reg, chars_s, chars_next;
    logic [LenW-1:0]        len_reg, len_s, len_next;
    logic                   long_reg, long_s, long_next;

    logic [7:0]             ch;
    logic [LineW-1:0]       line_inc;
    logic                   do_disp;
    logic                   finish;
    logic                   a_v, a_word, b_v;
    dtok_pkg::res_t         a_res, b_res;
    logic                   kw_hit;
    logic [4:0]             kw_kind;
    logic [4:0]             word_kind;

    function automatic logic [OffW-1:0] span(input logic [OffW-1:0] e,
                                            input logic [OffW-1:0] s);
        return (e >= s) ? (e - s) : '0;
    endfunction

    function automatic dtok_pkg::res_t mk(input logic [4:0]       kind,
                                         input logic [LineW-1:0] line,
                                         input logic [OffW-1:0]  off,
                                         input logic [OffW-1:0]  len);
        dtok_pkg::res_t r;
        logic [31:0]    l32;
        logic [63:0]    o64;
        logic [63:0]    n64;
        l32 = 32'(line);
        o64 = 64'(off);
        n64 = 64'(len);
        r.token_kind   = kind;
        r.token_line   = (|l32[31:24]) ? '1 : l32[23:0];
        r.token_offset = (|o64[63:32]) ? '1 : o64[31:0];
        r.token_length = (|n64[63:32]) ? '1 : n64[31:0];
        r.run_last     = 1'b0;
        return r;
    endfunction

    assign ch       = item.text_byte;
    assign line_inc = (&line_reg) ? line_reg : line_reg + 1'b1;

    // scan step for a content byte
    always_comb
    begin
        mode_s  = mode_reg;
        off_s   = off_reg;
        line_s  = line_reg;
        start_s = start_reg;
        sline_s = sline_reg;
        chars_s = chars_reg;
        len_s   = len_reg;
        long_s  = long_reg;
        a_v     = 1'b0;
        a_word  = 1'b0;
        a_res   = '0;
        b_v     = 1'b0;
        b_res   = '0;
        do_disp = 1'b0;
        if (fire && (ch != dtok_pkg::CH_NUL))
        begin
            off_s = (&off_reg) ? off_reg : off_reg + 1'b1;
            case (mode_reg)
                M_IDENT:
                begin
                    if (dtok_pkg::is_alpha(ch) || dtok_pkg::is_digit(ch))
                    begin
                        if (len_reg < LenW'(KwMax))
                        begin
                            chars_s[len_reg[IdxW-1:0]] = ch;
                            len_s = len_reg + 1'b1;
                        end
                        else
                        begin
                            long_s = 1'b1;
                        end
                    end
                    else
                    begin
                        a_v     = 1'b1;
                        a_word  = 1'b1;
                        a_res   = mk(dtok_pkg::K_IDENT, sline_reg, start_reg,
                                     span(off_reg, start_reg));
                        do_disp = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (!dtok_pkg::is_digit(ch))
                    begin
                        a_v     = 1'b1;
                        a_res   = mk(dtok_pkg::K_NUMBER, sline_reg, start_reg,
                                     span(off_reg, start_reg));
                        do_disp = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (ch == dtok_pkg::CH_QUOTE)
                    begin
                        a_v    = 1'b1;
                        a_res  = mk(dtok_pkg::K_STRING, sline_reg, start_reg,
                                    span(off_reg, start_reg));
                        mode_s = M_IDLE;
                    end
                    else if (ch == dtok_pkg::CH_BSLASH)
                    begin
                        mode_s = M_STR_ESC;
                    end
                end
                M_STR_ESC:
                begin
                    mode_s = M_STRING;
                end
                M_SLASH:
                begin
                    if (ch == dtok_pkg::CH_SLASH)
                    begin
                        mode_s = M_LINE_CMT;
                    end
                    else if (ch == dtok_pkg::CH_STAR)
                    begin
                        mode_s = M_BLOCK_CMT;
                    end
                    else
                    begin
                        a_v     = 1'b1;
                        a_res   = mk(dtok_pkg::K_OTHER, sline_reg, start_reg, OffW'(1));
                        do_disp = 1'b1;
                    end
                end
                M_LINE_CMT:
                begin
                    if (ch == dtok_pkg::CH_NL)
                    begin
                        do_disp = 1'b1;
                    end
                end
                M_BLOCK_CMT:
                begin
                    if (ch == dtok_pkg::CH_NL)
                    begin
                        line_s = line_inc;
                    end
                    else if (ch == dtok_pkg::CH_STAR)
                    begin
                        mode_s = M_BLOCK_STAR;
                    end
                end
                M_BLOCK_STAR:
                begin
                    if (ch == dtok_pkg::CH_SLASH)
                    begin
                        mode_s = M_IDLE;
                    end
                    else if (ch != dtok_pkg::CH_STAR)
                    begin
                        if (ch == dtok_pkg::CH_NL)
                        begin
                            line_s = line_inc;
                        end
                        mode_s = M_BLOCK_CMT;
                    end
                end
                default:
                begin
                    do_disp = 1'b1;
                end
            endcase

            // byte starts something new from the idle state
            if (do_disp)
            begin
                mode_s = M_IDLE;
                if (dtok_pkg::is_space(ch))
                begin
                    if (ch == dtok_pkg::CH_NL)
                    begin
                        line_s = line_inc;
                    end
                end
                else if (ch == dtok_pkg::CH_SLASH)
                begin
                    mode_s  = M_SLASH;
                    start_s = off_reg;
                    sline_s = line_reg;
                end
                else if (dtok_pkg::is_alpha(ch))
                begin
                    mode_s     = M_IDENT;
                    start_s    = off_reg;
                    sline_s    = line_reg;
                    chars_s[0] = ch;
                    len_s      = LenW'(1);
                    long_s     = 1'b0;
                end
                else if (dtok_pkg::is_digit(ch))
                begin
                    mode_s  = M_NUMBER;
                    start_s = off_reg;
                    sline_s = line_reg;
                end
                else if (ch == dtok_pkg::CH_QUOTE)
                begin
                    // contents start after the quote
                    mode_s  = M_STRING;
                    start_s = off_s;
                    sline_s = line_reg;
                end
                else
                begin
                    b_v   = 1'b1;
                    b_res = mk(dtok_pkg::punct_kind(ch), line_reg, off_reg, OffW'(1));
                end
            end
        end
    end

    // an emitted word never coexists with a changed identifier buffer
    dtok_kw_match #(
        .KwMax (KwMax),
        .LenW  (LenW)
    ) u_kw (
        .chars    (chars_s),
        .len      (len_s),
        .too_long (long_s),
        .hit      (kw_hit),
        .kind     (kw_kind)
    );

    assign word_kind = kw_hit ? kw_kind : dtok_pkg::K_IDENT;
    assign finish    = fire && ((ch == dtok_pkg::CH_NUL) || item.end_of_text);

    // end of text flush, result packing and next state
    always_comb
    begin
        dtok_pkg::res_t       cand [4];
        logic [3:0]           cv;
        logic [2:0]           n;
        cand[0] = a_res;
        if (a_word)
        begin
            cand[0].token_kind = word_kind;
        end
        cand[1] = b_res;
        cand[2] = '0;
        cand[3] = '0;
        cv      = {finish, 1'b0, b_v, a_v};
        if (finish)
        begin
            cand[3] = mk(dtok_pkg::K_EOF, line_s, off_s, '0);
            case (mode_s)
                M_IDENT:
                begin
                    cv[2]   = 1'b1;
                    cand[2] = mk(word_kind, sline_s, start_s, span(off_s, start_s));
                end
                M_NUMBER:
                begin
                    cv[2]   = 1'b1;
                    cand[2] = mk(dtok_pkg::K_NUMBER, sline_s, start_s, span(off_s, start_s));
                end
                M_STRING, M_STR_ESC:
                begin
                    cv[2]   = 1'b1;
                    cand[2] = mk(dtok_pkg::K_STRING, sline_s, start_s, span(off_s, start_s));
                end
                M_SLASH:
                begin
                    cv[2]   = 1'b1;
                    cand[2] = mk(dtok_pkg::K_OTHER, sline_s, start_s, OffW'(1));
                end
                default:
                begin
                    cv[2] = 1'b0;
                end
            endcase
        end

        push.slot = '0;
        n         = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (cv[j] && (n < 3'(dtok_pkg::MAX_RESULTS)))
            begin
                push.slot[n[1:0]] = cand[j];
                n = n + 1'b1;
            end
        end
        if (n != '0)
        begin
            push.slot[2'(n - 1'b1)].run_last = 1'b1;
        end
        push.n = n[1:0];

        if (finish)
        begin
            mode_next  = M_IDLE;
            off_next   = '0;
            line_next  = LineW'(1);
            start_next = '0;
            sline_next = LineW'(1);
            chars_next = '0;
            len_next   = '0;
            long_next  = 1'b0;
        end
        else
        begin
            mode_next  = mode_s;
            off_next   = off_s;
            line_next  = line_s;
            start_next = start_s;
            sline_next = sline_s;
            chars_next = chars_s;
            len_next   = len_s;
            long_next  = long_s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            off_reg   <= '0;
            line_reg  <= LineW'(1);
            start_reg <= '0;
            sline_reg <= LineW'(1);
            chars_reg <= '0;
            len_reg   <= '0;
            long_reg  <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
            start_reg <= start_next;
            sline_reg <= sline_next;
            chars_reg <= chars_next;
            len_reg   <= len_next;
            long_reg  <= long_next;
        end
    end

endmodule

>>> hdl/dtok_res_fifo.sv
// ----------------------------------------------------------------------------
// dtok_res_fifo
// Small result queue: takes up to three token words per cycle, hands out one
// per cycle while pop_ready is high, from a registered head entry.
// ----------------------------------------------------------------------------
module dtok_res_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtok_pkg::push_t      push,
    input  logic                 pop_ready,
    output logic                 head_valid,
    output dtok_pkg::res_t       head_data,
    output dtok_pkg::fifo_stat_t stat
);

    localparam int PtrW = $clog2(dtok_pkg::FIFO_DEPTH);
    localparam int CntW = $clog2(dtok_pkg::FIFO_DEPTH + 1);

    dtok_pkg::res_t  mem_reg [dtok_pkg::FIFO_DEPTH];
    logic [PtrW-1:0] head_reg, head_next;
    logic [PtrW-1:0] tail_reg, tail_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            pop;

    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[head_reg];
    assign pop        = head_valid && pop_ready;

    // room for a worst-case byte once this cycle's pop is counted
    assign stat.room  = (count_reg - CntW'(pop)) <= CntW'(dtok_pkg::FIFO_DEPTH
                                                          - dtok_pkg::MAX_RESULTS);
    assign stat.count = 3'(count_reg);

    assign head_next  = head_reg + PtrW'(pop);
    assign tail_next  = tail_reg + PtrW'(push.n);
    assign count_next = count_reg + CntW'(push.n) - CntW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < dtok_pkg::MAX_RESULTS; j++)
        begin
            if (2'(j) < push.n)
            begin
                mem_reg[PtrW'(tail_reg + PtrW'(j))] <= push.slot[j];
            end
        end
    end

endmodule

>>> hdl/c_declaration_tokenizer_core.sv
// ----------------------------------------------------------------------------
// c_declaration_tokenizer_core
// A byte accepted into the input register is scanned once the result queue
// has room for its worst case; its token words then go through the queue to
// out_data. Throughput: one byte per cycle while each byte yields at most one
// token and out_ready holds; a byte that yields more tokens is buffered by a
// four-word result queue, and a new byte waits while the queue lacks room.
// Reset: rst_n clears the scan state to line 1, offset 0, and empties the input register and the result queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module c_declaration_tokenizer_core #(
    parameter int OFFSET_BITS     = dtok_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS       = dtok_pkg::LINE_BITS_DEF,
    parameter int KEYWORD_MAX_LEN = dtok_pkg::KEYWORD_MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dtok_pkg::in_word_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dtok_pkg::res_t     out_data
);

    logic                 in_valid_reg;
    dtok_pkg::in_word_t   in_reg;
    logic                 fire;
    dtok_pkg::push_t      push;
    dtok_pkg::fifo_stat_t fifo_stat;

    // scan the held byte once the queue can take its worst case
    assign fire     = in_valid_reg && fifo_stat.room;
    assign in_ready = !in_valid_reg || fifo_stat.room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_reg <= in_data;
        end
    end

    dtok_scan #(
        .OffW  (OFFSET_BITS),
        .LineW (LINE_BITS),
        .KwMax (KEYWORD_MAX_LEN)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (in_reg),
        .push  (push)
    );

    dtok_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop_ready  (out_ready),
        .head_valid (out_valid),
        .head_data  (out_data),
        .stat       (fifo_stat)
    );

    `ASSERT_NEVER(a_push_without_fire, clk, rst_n, (push.n != 2'd0) && !fire, "tokens without a scanned byte")
    `ASSERT_IMPLY(a_end_gives_eof, clk, rst_n, fire && ((in_reg.text_byte == dtok_pkg::CH_NUL) || in_reg.end_of_text), push.n != 2'd0, "end of text without tokens")
    `ASSERT_NEVER(a_fifo_overflow, clk, rst_n, fifo_stat.count > 3'(dtok_pkg::FIFO_DEPTH), "result queue overflow")
    `ASSERT_NEVER(a_stall_needs_item, clk, rst_n, !in_ready && !in_valid_reg, "input stalled with empty register")

endmodule
